FILE: sv/binary_threshold_edge_marker_defines.svh
// assertion macros for the binary threshold edge marker
`ifndef BINARY_THRESHOLD_EDGE_MARKER_DEFINES_SVH
`define BINARY_THRESHOLD_EDGE_MARKER_DEFINES_SVH

// checked only while reset is low
`define BTE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define BTE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/bte_pkg.sv
// shared types and constants for the binary threshold edge marker
package bte_pkg;

   localparam int CFG_W = 13;
   localparam logic [CFG_W-1:0] LINE_LENGTH_RESET = 13'd640;

   // (r+g+b)/3 >= 128 is the same as r+g+b >= 384
   localparam int SUM_W = 10;
   localparam logic [SUM_W-1:0] THRESH_SUM = 10'd384;

   localparam logic [7:0] LEVEL_HIGH = 8'd255;
   localparam logic [7:0] LEVEL_LOW  = 8'd0;

   // what the first stage passes on to the level decision
   typedef struct packed {
      logic pix_bit;
      logic check;
      logic left_bit;
   } stage_type;

endpackage

FILE: sv/binary_threshold_edge_marker.sv
// Binary threshold edge marker: takes one RGB pixel per clock in raster order and
// returns one level per pixel, 255 where the thresholded pixel matches its left and
// upper neighbors (or, in the first row or column, where it is bright) and 0 on an
// edge. One item is accepted every cycle while the result side keeps up; an accepted
// item passes through two register stages (a first stage aligned with the read of the
// line store, then the result register) before its result appears. The previous
// line's bits sit in a 1-bit-wide memory of MAX_LINE entries that is read and written
// once per item at the item's column; it needs no clearing after reset. req_frame_start
// restarts row and column counting. csr_line_length may be written only while idle;
// 0 acts as 1 and values above MAX_LINE act as MAX_LINE.
module binary_threshold_edge_marker #(
   parameter int MAX_LINE = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_red,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_blue,
   input  logic                      req_frame_start,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_out_level,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [bte_pkg::CFG_W-1:0] csr_line_length
);
   import bte_pkg::*;

   localparam int COL_W = (MAX_LINE > 2) ? $clog2(MAX_LINE) : 1;
   localparam int LIM_W = $clog2(MAX_LINE + 1);
   localparam int LEN_W = (LIM_W > CFG_W) ? LIM_W : CFG_W;
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LINE);

   logic [CFG_W-1:0] line_length_ff;
   logic [COL_W-1:0] column_ff, column_in;
   logic             past_first_row_ff, past_first_row_in;
   logic             left_bit_ff;
   logic             a_valid_ff, a_valid_in;
   stage_type        a_stage_ff, a_stage_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_level_ff, out_level_in;

   logic             accept;
   logic             advance_a;
   logic [LEN_W-1:0] len_eff;
   logic [LEN_W-1:0] len_cfg;
   logic [COL_W-1:0] col_start;
   logic [COL_W-1:0] col;
   logic [LEN_W-1:0] col_inc;
   logic             pfr_cur;
   logic [SUM_W-1:0] sum;
   logic             pix_bit;
   logic             above_bit;

   assign csr_ready = 1'b1;
   assign advance_a = !out_valid_ff || rsp_ready;
   assign req_ready = !a_valid_ff || advance_a;
   assign accept    = req_valid && req_ready;

   always_comb begin
      len_cfg = LEN_W'(line_length_ff);
      if (len_cfg == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_cfg > LEN_LIMIT) begin
         len_eff = LEN_LIMIT;
      end else begin
         len_eff = len_cfg;
      end

      col_start = req_frame_start ? '0 : column_ff;
      pfr_cur   = req_frame_start ? 1'b0 : past_first_row_ff;
      col       = (LEN_W'(col_start) >= len_eff) ? '0 : col_start;

      sum     = SUM_W'(req_red) + SUM_W'(req_green) + SUM_W'(req_blue);
      pix_bit = (sum >= THRESH_SUM);

      // advance the column, wrap at the line end and mark the row done
      col_inc = LEN_W'(col) + LEN_W'(1);
      if (col_inc >= len_eff) begin
         column_in         = '0;
         past_first_row_in = 1'b1;
      end else begin
         column_in         = col_inc[COL_W-1:0];
         past_first_row_in = pfr_cur;
      end

      a_stage_in.pix_bit  = pix_bit;
      a_stage_in.check    = pfr_cur && (col != '0);
      a_stage_in.left_bit = left_bit_ff;

      if (accept) begin
         a_valid_in = 1'b1;
      end else if (advance_a) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end

      if (!a_stage_ff.check) begin
         out_level_in = a_stage_ff.pix_bit ? LEVEL_HIGH : LEVEL_LOW;
      end else if ((a_stage_ff.pix_bit == a_stage_ff.left_bit) &&
                   (a_stage_ff.pix_bit == above_bit)) begin
         out_level_in = LEVEL_HIGH;
      end else begin
         out_level_in = LEVEL_LOW;
      end

      if (a_valid_ff && advance_a) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // read returns the bit from the line above before this item overwrites it
   bte_ram #(
      .WIDTH (1),
      .DEPTH (MAX_LINE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr ($clog2(MAX_LINE)'(col)),
      .wr_data (pix_bit),
      .rd_en   (accept),
      .rd_addr ($clog2(MAX_LINE)'(col)),
      .rd_data (above_bit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff    <= LINE_LENGTH_RESET;
         column_ff         <= '0;
         past_first_row_ff <= 1'b0;
         left_bit_ff       <= 1'b0;
         a_valid_ff        <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            line_length_ff <= csr_line_length;
         end
         if (accept) begin
            column_ff         <= column_in;
            past_first_row_ff <= past_first_row_in;
            left_bit_ff       <= pix_bit;
         end
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_stage_ff <= a_stage_in;
      end
      if (a_valid_ff && advance_a) begin
         out_level_ff <= out_level_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_level = out_level_ff;

endmodule

FILE: sv/bte_ram.sv
// generic simple dual-port ram, registered read, old data on same-address access
module bte_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/bte_checker.sv
// port-level checks for the binary threshold edge marker, with its bind
`include "binary_threshold_edge_marker_defines.svh"

module bte_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_level
);
   import bte_pkg::*;

   logic level_ok;
   logic rsp_stalled;

   assign level_ok    = (rsp_out_level == LEVEL_HIGH) || (rsp_out_level == LEVEL_LOW);
   assign rsp_stalled = rsp_valid && !rsp_ready;

   // the result register is emptied by reset
   `BTE_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

   // a result is always black or white
   `BTE_ASSERT(a_level_binary, rsp_valid |-> level_ok, "level neither 0 nor 255")

   // a stalled result holds
   `BTE_ASSERT(a_rsp_hold, rsp_stalled |=> (rsp_valid && $stable(rsp_out_level)), "stalled result changed")

endmodule

bind binary_threshold_edge_marker bte_checker u_bte_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_level (rsp_out_level)
);
